[rtl/rau_pkg.sv]
// Shared types, codes and constants of the rational arithmetic unit.
package rau_pkg;

    // Magnitudes inside the datapath are carried at this width.
    localparam int MAG_W = 64;

    // Operation codes.
    localparam logic [3:0] CMD_ADD   = 4'd0;
    localparam logic [3:0] CMD_SUB   = 4'd1;
    localparam logic [3:0] CMD_MUL   = 4'd2;
    localparam logic [3:0] CMD_DIV   = 4'd3;
    localparam logic [3:0] CMD_NEG   = 4'd4;
    localparam logic [3:0] CMD_ABS   = 4'd5;
    localparam logic [3:0] CMD_FRAC  = 4'd6;
    localparam logic [3:0] CMD_INT   = 4'd7;
    localparam logic [3:0] CMD_FLOOR = 4'd8;
    localparam logic [3:0] CMD_CEIL  = 4'd9;
    localparam logic [3:0] CMD_ROUND = 4'd10;
    localparam logic [3:0] CMD_EQ    = 4'd11;
    localparam logic [3:0] CMD_LT    = 4'd12;

    // Status codes.
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_DIV0 = 2'd1;
    localparam logic [1:0] STAT_OVF  = 2'd2;

    typedef struct packed {
        logic [3:0]         cmd;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic signed [31:0] b_den;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] res_num;
        logic [30:0]        res_den;
        logic               compare_true;
        logic [1:0]         status;
    } t_out_item;

    // Control that the divider broadcasts to every cell of its row.
    typedef struct packed {
        logic load;
        logic step;
        logic take;
    } t_cell_ctl;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_GCD,
        ST_RED1,
        ST_RED2,
        ST_RED3,
        ST_DIV,
        ST_MUL,
        ST_A_DONE,
        ST_B_DONE,
        ST_OP,
        ST_MD1,
        ST_MD2,
        ST_LT1,
        ST_LT2,
        ST_ADD1,
        ST_ADD2,
        ST_ADD3,
        ST_ADD4,
        ST_ADD5,
        ST_ADD6,
        ST_QR,
        ST_FIN
    } t_state;

endpackage

[rtl/rau_cell.sv]
// One bit slice of the shift-subtract divider row.
module rau_cell (
    input  logic               i_clk,
    input  rau_pkg::t_cell_ctl i_ctl,
    input  logic               i_load_d,
    input  logic               i_load_q,
    input  logic               i_rem_in,
    input  logic               i_q_in,
    input  logic               i_borrow_in,
    output logic               o_rem,
    output logic               o_q,
    output logic               o_borrow
);
    import rau_pkg::*;

    logic r_rem;
    logic r_d;
    logic r_q;
    logic w_diff;

    // Trial subtraction of the divisor bit, borrow ripples to the next cell.
    assign w_diff   = i_rem_in ^ r_d ^ i_borrow_in;
    assign o_borrow = (~i_rem_in & r_d) | (~(i_rem_in ^ r_d) & i_borrow_in);
    assign o_rem    = r_rem;
    assign o_q      = r_q;

    // Load the operands, or shift one place and keep or drop the difference.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_rem <= 1'b0;
            r_d   <= i_load_d;
            r_q   <= i_load_q;
        end else if (i_ctl.step) begin
            r_rem <= i_ctl.take ? w_diff : i_rem_in;
            r_q   <= i_q_in;
        end
    end

endmodule

[rtl/rau_div.sv]
// Restoring divider built as a row of bit cells, one quotient bit per cycle.
module rau_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [rau_pkg::MAG_W-1:0] i_dividend,
    input  logic [rau_pkg::MAG_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [rau_pkg::MAG_W-1:0] o_quot,
    output logic [rau_pkg::MAG_W-1:0] o_rem
);
    import rau_pkg::*;

    localparam int CW = $clog2(MAG_W);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [MAG_W-1:0] w_rem;
    logic [MAG_W-1:0] w_q;
    logic [MAG_W-1:0] w_bout;
    logic             w_take;
    t_cell_ctl        w_ctl;

    // The shifted remainder fits the divisor when its top bit is set or no borrow remains.
    assign w_take     = w_rem[MAG_W-1] | ~w_bout[MAG_W-1];
    assign w_ctl.load = i_start;
    assign w_ctl.step = r_busy;
    assign w_ctl.take = w_take;

    // The row of cells; the top quotient bit wraps into the bottom remainder bit.
    for (genvar i = 0; i < MAG_W; i++) begin : g_cell
        logic w_rin;
        logic w_qin;
        logic w_bin;
        if (i == 0) begin : g_first
            assign w_rin = w_q[MAG_W-1];
            assign w_qin = w_take;
            assign w_bin = 1'b0;
        end else begin : g_next
            assign w_rin = w_rem[i-1];
            assign w_qin = w_q[i-1];
            assign w_bin = w_bout[i-1];
        end
        rau_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_load_d    (i_divisor[i]),
            .i_load_q    (i_dividend[i]),
            .i_rem_in    (w_rin),
            .i_q_in      (w_qin),
            .i_borrow_in (w_bin),
            .o_rem       (w_rem[i]),
            .o_q         (w_q[i]),
            .o_borrow    (w_bout[i])
        );
    end

    // Step counter: one step per quotient bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(MAG_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = w_q;
    assign o_rem  = w_rem;

endmodule

[rtl/rational_arithmetic_unit.sv]
// Rational arithmetic unit: top level sequencer, gcd loop, multiplier and divider.
// One item at a time. An input error or an unused code goes from idle straight to the final step;
// other items spend their time in the 64-step bit-cell divider and the binary gcd loop (one
// subtract or shift a cycle) of each normalization.
// A new item is taken while the previous result still waits in the output register.
// Reset (synchronous, active low) empties the block and the output register.
module rational_arithmetic_unit #(
    parameter int WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  rau_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output rau_pkg::t_out_item o_out_data
);
    import rau_pkg::*;

    localparam int EFF_W = (WIDTH < 32) ? WIDTH : 32;
    localparam int KW    = $clog2(MAG_W);
    localparam logic [MAG_W-1:0] LIM = MAG_W'(1) << (EFF_W - 1);

    t_state           r_state, n_state;
    t_state           r_gcd_ret, r_red_ret, r_div_ret, r_mul_ret;
    logic [3:0]       r_cmd;
    logic [1:0]       r_st;
    logic             r_cmp;
    logic             r_aneg, r_bneg, r_rneg;
    logic [32:0]      r_an, r_ad, r_bn, r_bd;
    logic [32:0]      r_t0, r_t1, r_ma, r_mb;
    logic [MAG_W-1:0] r_rn, r_rd, r_gx, r_gy, r_g, r_x, r_y, r_prod;
    logic [MAG_W-1:0] r_dv_n, r_dv_d;
    logic [KW-1:0]    r_gk;
    logic             r_div_go;
    logic             r_out_valid;
    t_out_item        r_out;

    logic             w_in_acc;
    logic             w_in_bin;
    logic             w_in_err;
    logic             w_binary;
    logic             w_gcd_done;
    logic [MAG_W-1:0] w_gcd;
    logic             w_div_done;
    logic [MAG_W-1:0] w_quot, w_rem;
    logic [MAG_W-1:0] w_prod;
    logic             w_fin_load;
    logic             w_inc;
    logic [MAG_W-1:0] w_whole;
    logic             w_ok;
    logic [MAG_W-1:0] w_num;
    logic             w_sb, w_sum_neg;
    logic [MAG_W-1:0] w_sum;
    logic             w_xn, w_yn, w_lt;

    // Magnitude of a 32-bit field; the most negative value maps to 2^32.
    function automatic logic [32:0] f_mag(input logic [31:0] v);
        return (v == 32'h8000_0000) ? 33'h1_0000_0000 :
               (v[31] ? {1'b0, ~v + 32'd1} : {1'b0, v});
    endfunction

    function automatic logic f_is_binary(input logic [3:0] c);
        return (c == CMD_ADD) || (c == CMD_SUB) || (c == CMD_MUL) || (c == CMD_DIV) ||
               (c == CMD_EQ) || (c == CMD_LT);
    endfunction

    // Shared divider.
    rau_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_go),
        .i_dividend (r_dv_n),
        .i_divisor  (r_dv_d),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    // Item decode at the input.
    assign w_in_acc = i_in_valid && !o_in_stall;
    assign w_in_bin = f_is_binary(i_in_data.cmd);
    assign w_in_err = (i_in_data.a_den == 32'sd0) ||
                      (w_in_bin && (i_in_data.b_den == 32'sd0)) ||
                      ((i_in_data.cmd == CMD_DIV) && (i_in_data.b_num == 32'sd0));
    assign w_binary = f_is_binary(r_cmd);

    // Binary gcd: finished when one side reaches zero.
    assign w_gcd_done = (r_gx == '0) || (r_gy == '0);
    assign w_gcd      = (r_gx | r_gy) << r_gk;

    // Multiplier operands are 33 bits, the product is kept to 64 bits and registered.
    assign w_prod = MAG_W'(r_ma) * MAG_W'(r_mb);

    // Integer results from the truncating quotient and remainder.
    always_comb begin
        w_inc = 1'b0;
        case (r_cmd)
            CMD_FLOOR: w_inc = r_aneg && (w_rem != '0);
            CMD_CEIL:  w_inc = !r_aneg && (w_rem != '0);
            CMD_ROUND: w_inc = r_aneg ? ((w_rem << 1) > MAG_W'(r_ad))
                                      : ((w_rem << 1) >= MAG_W'(r_ad));
            default:   w_inc = 1'b0;
        endcase
    end
    assign w_whole = w_quot + MAG_W'(w_inc);

    // Signed sum of the two scaled numerators.
    assign w_sb = (r_cmd == CMD_SUB) ? !r_bneg : r_bneg;
    always_comb begin
        if (r_aneg == w_sb) begin
            w_sum_neg = r_aneg;
            w_sum     = r_x + r_y;
        end else if (r_x >= r_y) begin
            w_sum_neg = r_aneg;
            w_sum     = r_x - r_y;
        end else begin
            w_sum_neg = w_sb;
            w_sum     = r_y - r_x;
        end
    end

    // Less-than on the cross products.
    assign w_xn = r_aneg && (r_x != '0);
    assign w_yn = r_bneg && (r_prod != '0);
    assign w_lt = (w_xn != w_yn) ? w_xn : (w_xn ? (r_x > r_prod) : (r_x < r_prod));

    // Range check of the final result.
    assign w_ok  = (r_rneg ? (r_rn <= LIM) : (r_rn < LIM)) && (r_rd < LIM);
    assign w_num = r_rneg ? (MAG_W'(0) - r_rn) : r_rn;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if ((i_in_data.cmd > CMD_LT) || w_in_err) begin
                        n_state = ST_FIN;
                    end else begin
                        n_state = ST_GCD;
                    end
                end
            end
            ST_GCD:    if (w_gcd_done) n_state = r_gcd_ret;
            ST_RED1:   n_state = ST_DIV;
            ST_RED2:   n_state = ST_DIV;
            ST_RED3:   n_state = r_red_ret;
            ST_DIV:    if (w_div_done) n_state = r_div_ret;
            ST_MUL:    n_state = r_mul_ret;
            ST_A_DONE: n_state = w_binary ? ST_GCD : ST_OP;
            ST_B_DONE: n_state = ST_OP;
            ST_OP: begin
                case (r_cmd)
                    CMD_ADD, CMD_SUB:                 n_state = ST_GCD;
                    CMD_MUL, CMD_DIV, CMD_LT:         n_state = ST_MUL;
                    CMD_FRAC, CMD_INT, CMD_FLOOR,
                    CMD_CEIL, CMD_ROUND:              n_state = ST_DIV;
                    default:                          n_state = ST_FIN;
                endcase
            end
            ST_MD1:    n_state = ST_MUL;
            ST_MD2:    n_state = ST_GCD;
            ST_LT1:    n_state = ST_MUL;
            ST_LT2:    n_state = ST_FIN;
            ST_ADD1:   n_state = ST_DIV;
            ST_ADD2:   n_state = ST_DIV;
            ST_ADD3:   n_state = ST_MUL;
            ST_ADD4:   n_state = ST_MUL;
            ST_ADD5:   n_state = ST_MUL;
            ST_ADD6:   n_state = ST_GCD;
            ST_QR:     n_state = ST_FIN;
            ST_FIN:    if (w_fin_load) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb begin
        o_in_stall = (r_state != ST_IDLE);
        w_fin_load = (r_state == ST_FIN) && (!r_out_valid || !i_out_stall);
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_div_go    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_div_go <= ((r_state == ST_OP) && (n_state == ST_DIV)) ||
                        (r_state == ST_RED1) || (r_state == ST_RED2) ||
                        (r_state == ST_ADD1) || (r_state == ST_ADD2);
            if (w_fin_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers, written per step of the sequence.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_cmd  <= i_in_data.cmd;
                r_cmp  <= 1'b0;
                r_bn   <= f_mag(i_in_data.b_num);
                r_bd   <= f_mag(i_in_data.b_den);
                r_bneg <= i_in_data.b_num[31] ^ i_in_data.b_den[31];
                r_st   <= w_in_err && !(i_in_data.cmd > CMD_LT) ? STAT_DIV0 : STAT_OK;
                if ((i_in_data.cmd > CMD_LT) || w_in_err) begin
                    r_rn   <= '0;
                    r_rd   <= MAG_W'(1);
                    r_rneg <= 1'b0;
                end else begin
                    r_rn      <= MAG_W'(f_mag(i_in_data.a_num));
                    r_rd      <= MAG_W'(f_mag(i_in_data.a_den));
                    r_rneg    <= i_in_data.a_num[31] ^ i_in_data.a_den[31];
                    r_gx      <= MAG_W'(f_mag(i_in_data.a_num));
                    r_gy      <= MAG_W'(f_mag(i_in_data.a_den));
                    r_gk      <= '0;
                    r_gcd_ret <= ST_RED1;
                    r_red_ret <= ST_A_DONE;
                end
            end
            ST_GCD: begin
                if (w_gcd_done) begin
                    r_g <= (w_gcd == '0) ? MAG_W'(1) : w_gcd;
                end else if (!r_gx[0] && !r_gy[0]) begin
                    r_gx <= r_gx >> 1;
                    r_gy <= r_gy >> 1;
                    r_gk <= r_gk + 1'b1;
                end else if (!r_gx[0]) begin
                    r_gx <= r_gx >> 1;
                end else if (!r_gy[0]) begin
                    r_gy <= r_gy >> 1;
                end else if (r_gx >= r_gy) begin
                    r_gx <= r_gx - r_gy;
                end else begin
                    r_gy <= r_gy - r_gx;
                end
            end
            ST_RED1: begin
                r_dv_n    <= r_rn;
                r_dv_d    <= r_g;
                r_div_ret <= ST_RED2;
            end
            ST_RED2: begin
                r_rn      <= w_quot;
                r_dv_n    <= r_rd;
                r_dv_d    <= r_g;
                r_div_ret <= ST_RED3;
            end
            ST_RED3: begin
                r_rd   <= w_quot;
                r_rneg <= r_rneg && (r_rn != '0);
            end
            ST_MUL: begin
                r_prod <= w_prod;
            end
            ST_A_DONE: begin
                r_an   <= r_rn[32:0];
                r_ad   <= r_rd[32:0];
                r_aneg <= r_rneg;
                if (w_binary) begin
                    r_rn      <= MAG_W'(r_bn);
                    r_rd      <= MAG_W'(r_bd);
                    r_rneg    <= r_bneg;
                    r_gx      <= MAG_W'(r_bn);
                    r_gy      <= MAG_W'(r_bd);
                    r_gk      <= '0;
                    r_gcd_ret <= ST_RED1;
                    r_red_ret <= ST_B_DONE;
                end
            end
            ST_B_DONE: begin
                r_bn   <= r_rn[32:0];
                r_bd   <= r_rd[32:0];
                r_bneg <= r_rneg;
            end
            ST_OP: begin
                unique case (r_cmd)
                    CMD_ADD, CMD_SUB: begin
                        r_gx      <= MAG_W'(r_ad);
                        r_gy      <= MAG_W'(r_bd);
                        r_gk      <= '0;
                        r_gcd_ret <= ST_ADD1;
                    end
                    CMD_MUL: begin
                        r_ma      <= r_an;
                        r_mb      <= r_bn;
                        r_mul_ret <= ST_MD1;
                    end
                    CMD_DIV: begin
                        r_ma      <= r_an;
                        r_mb      <= r_bd;
                        r_mul_ret <= ST_MD1;
                    end
                    CMD_LT: begin
                        r_ma      <= r_an;
                        r_mb      <= r_bd;
                        r_mul_ret <= ST_LT1;
                    end
                    CMD_NEG: begin
                        r_rn   <= MAG_W'(r_an);
                        r_rd   <= MAG_W'(r_ad);
                        r_rneg <= !r_aneg && (r_an != '0);
                    end
                    CMD_ABS: begin
                        r_rn   <= MAG_W'(r_an);
                        r_rd   <= MAG_W'(r_ad);
                        r_rneg <= 1'b0;
                    end
                    CMD_EQ: begin
                        r_cmp  <= (r_aneg == r_bneg) && (r_an == r_bn) && (r_ad == r_bd);
                        r_rn   <= '0;
                        r_rd   <= MAG_W'(1);
                        r_rneg <= 1'b0;
                    end
                    CMD_FRAC, CMD_INT, CMD_FLOOR, CMD_CEIL, CMD_ROUND: begin
                        r_dv_n    <= MAG_W'(r_an);
                        r_dv_d    <= MAG_W'(r_ad);
                        r_div_ret <= ST_QR;
                    end
                    default: begin
                        r_rn   <= '0;
                        r_rd   <= MAG_W'(1);
                        r_rneg <= 1'b0;
                    end
                endcase
            end
            ST_MD1: begin
                r_x       <= r_prod;
                r_ma      <= r_ad;
                r_mb      <= (r_cmd == CMD_DIV) ? r_bn : r_bd;
                r_mul_ret <= ST_MD2;
            end
            ST_MD2: begin
                r_rn      <= r_x;
                r_rd      <= r_prod;
                r_rneg    <= r_aneg != r_bneg;
                r_gx      <= r_x;
                r_gy      <= r_prod;
                r_gk      <= '0;
                r_gcd_ret <= ST_RED1;
                r_red_ret <= ST_FIN;
            end
            ST_LT1: begin
                r_x       <= r_prod;
                r_ma      <= r_bn;
                r_mb      <= r_ad;
                r_mul_ret <= ST_LT2;
            end
            ST_LT2: begin
                r_cmp  <= w_lt;
                r_rn   <= '0;
                r_rd   <= MAG_W'(1);
                r_rneg <= 1'b0;
            end
            ST_ADD1: begin
                r_dv_n    <= MAG_W'(r_ad);
                r_dv_d    <= r_g;
                r_div_ret <= ST_ADD2;
            end
            ST_ADD2: begin
                r_t0      <= w_quot[32:0];
                r_dv_n    <= MAG_W'(r_bd);
                r_dv_d    <= r_g;
                r_div_ret <= ST_ADD3;
            end
            ST_ADD3: begin
                r_t1      <= w_quot[32:0];
                r_ma      <= r_an;
                r_mb      <= w_quot[32:0];
                r_mul_ret <= ST_ADD4;
            end
            ST_ADD4: begin
                r_x       <= r_prod;
                r_ma      <= r_bn;
                r_mb      <= r_t0;
                r_mul_ret <= ST_ADD5;
            end
            ST_ADD5: begin
                r_y       <= r_prod;
                r_ma      <= r_ad;
                r_mb      <= r_t1;
                r_mul_ret <= ST_ADD6;
            end
            ST_ADD6: begin
                r_rn      <= w_sum;
                r_rd      <= r_prod;
                r_rneg    <= w_sum_neg;
                r_gx      <= w_sum;
                r_gy      <= r_prod;
                r_gk      <= '0;
                r_gcd_ret <= ST_RED1;
                r_red_ret <= ST_FIN;
            end
            ST_QR: begin
                if (r_cmd == CMD_FRAC) begin
                    r_rn   <= w_rem;
                    r_rd   <= MAG_W'(r_ad);
                    r_rneg <= r_aneg && (w_rem != '0);
                end else begin
                    r_rn   <= w_whole;
                    r_rd   <= MAG_W'(1);
                    r_rneg <= r_aneg && (w_whole != '0);
                end
            end
            ST_FIN: begin
                if (w_fin_load) begin
                    if ((r_st != STAT_OK) || !w_ok) begin
                        r_out.res_num      <= '0;
                        r_out.res_den      <= 31'd1;
                        r_out.compare_true <= 1'b0;
                        r_out.status       <= (r_st != STAT_OK) ? r_st : STAT_OVF;
                    end else begin
                        r_out.res_num      <= w_num[31:0];
                        r_out.res_den      <= r_rd[30:0];
                        r_out.compare_true <= r_cmp;
                        r_out.status       <= STAT_OK;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // The divider only finishes while the sequencer waits on it.
    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside its wait step");

    // A failed result always carries the fixed zero value.
    a_err_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status != STAT_OK)) |->
        ((o_out_data.res_num == 32'sd0) && (o_out_data.res_den == 31'd1) &&
         !o_out_data.compare_true))
        else $error("error result with a nonzero value");

    // Finishing an item leaves a valid result behind.
    a_fin_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fin_load |=> (o_out_valid && (r_state == ST_IDLE)))
        else $error("finished item not presented");

    // Items are taken only while the sequencer is idle.
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state != ST_IDLE) && ($past(r_state) == ST_IDLE))
        else $error("item accepted outside idle");

endmodule
